[rtl/ssd_pkg.sv]
package ssd_pkg;

	localparam int FreqW       = 16;
	localparam int AmpW        = 7;
	localparam int WaveW       = 4;
	localparam int PosW        = 3;
	localparam int DwellW      = 16;
	localparam int AddrW       = 4;
	localparam int DataW       = 32;
	localparam int BcdFW       = 20;
	localparam int BcdAW       = 8;
	localparam int BinAW       = 8;
	localparam int BitsPerCell = 2;
	localparam int NumCells    = FreqW / BitsPerCell;

	localparam logic [1:0] RegWaveMode  = 2'd0;
	localparam logic [1:0] RegFrequency = 2'd1;
	localparam logic [1:0] RegAmplitude = 2'd2;
	localparam logic [1:0] RegDwell     = 2'd3;

	localparam logic [PosW-1:0] PosMode     = 3'd0;
	localparam logic [PosW-1:0] PosDashA    = 3'd1;
	localparam logic [PosW-1:0] PosFreqTens = 3'd2;
	localparam logic [PosW-1:0] PosFreqUnit = 3'd3;
	localparam logic [PosW-1:0] PosFreqFrac = 3'd4;
	localparam logic [PosW-1:0] PosDashB    = 3'd5;
	localparam logic [PosW-1:0] PosAmpUnit  = 3'd6;
	localparam logic [PosW-1:0] PosAmpFrac  = 3'd7;

	localparam logic [7:0]        SegDash    = 8'h40;
	localparam logic [7:0]        SegDot     = 8'h80;
	localparam logic [15:0]       BlankWord  = 16'hFFFF;
	localparam logic [FreqW-1:0]  FreqLow    = 16'd100;
	localparam logic [FreqW-1:0]  FreqHigh   = 16'd20000;
	localparam logic [AmpW-1:0]   AmpMax     = 7'd99;
	localparam logic [DwellW-1:0] DwellReset = 16'd50;

	typedef struct packed {
		logic [PosW-1:0]  pos;
		logic             blank;
		logic [WaveW-1:0] wave;
		logic [FreqW-1:0] bin_f;
		logic [BcdFW-1:0] bcd_f;
		logic [BinAW-1:0] bin_a;
		logic [BcdAW-1:0] bcd_a;
	} item_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		case (d)
			4'd0: g = 8'h3f;
			4'd1: g = 8'h06;
			4'd2: g = 8'h5b;
			4'd3: g = 8'h4f;
			4'd4: g = 8'h66;
			4'd5: g = 8'h6d;
			4'd6: g = 8'h7d;
			4'd7: g = 8'h07;
			4'd8: g = 8'h7f;
			4'd9: g = 8'h6f;
			default: g = SegDash;
		endcase
		return g;
	endfunction

	function automatic logic [BcdFW-1:0] adjust_f(input logic [BcdFW-1:0] x);
		logic [BcdFW-1:0] r;
		r = x;
		for (int i = 0; i < BcdFW / 4; i++) begin
			if (x[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = x[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	function automatic logic [BcdAW-1:0] adjust_a(input logic [BcdAW-1:0] x);
		logic [BcdAW-1:0] r;
		r = x;
		for (int i = 0; i < BcdAW / 4; i++) begin
			if (x[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = x[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

endpackage

[rtl/ssd_cell.sv]
module ssd_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  ssd_pkg::item_t item_in,
	input  logic          valid_in,
	output logic          ready_up,
	input  logic          ready_dn,
	output ssd_pkg::item_t item_out,
	output logic          valid_out
);

	logic                       valid_q;
	ssd_pkg::item_t             item_q;
	ssd_pkg::item_t             item_nxt;
	logic [ssd_pkg::BcdFW-1:0]  f1;
	logic [ssd_pkg::BcdFW-1:0]  f1_sh;
	logic [ssd_pkg::BcdFW-1:0]  f2;
	logic [ssd_pkg::BcdAW-1:0]  a1;

	// two frequency bits and one amplitude bit per cell
	always_comb begin
		item_nxt = item_in;
		f1       = ssd_pkg::adjust_f(item_in.bcd_f);
		f1_sh    = {f1[ssd_pkg::BcdFW-2:0], item_in.bin_f[ssd_pkg::FreqW-1]};
		f2       = ssd_pkg::adjust_f(f1_sh);
		item_nxt.bcd_f = {f2[ssd_pkg::BcdFW-2:0], item_in.bin_f[ssd_pkg::FreqW-2]};
		item_nxt.bin_f = {item_in.bin_f[ssd_pkg::FreqW-3:0], 2'b00};
		a1       = ssd_pkg::adjust_a(item_in.bcd_a);
		item_nxt.bcd_a = {a1[ssd_pkg::BcdAW-2:0], item_in.bin_a[ssd_pkg::BinAW-1]};
		item_nxt.bin_a = {item_in.bin_a[ssd_pkg::BinAW-2:0], 1'b0};
	end

	assign ready_up  = !valid_q || ready_dn;
	assign valid_out = valid_q;
	assign item_out  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_up) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_in) begin
			item_q <= item_nxt;
		end
	end

endmodule

[rtl/ssd_scan.sv]
module ssd_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssd_pkg::AddrW-1:0]   paddr,
	input  logic [ssd_pkg::DataW-1:0]   pwdata,
	output logic [ssd_pkg::DataW-1:0]   prdata,
	input  logic                        accept,
	input  logic                        tick,
	output ssd_pkg::item_t              entry
);

	logic [ssd_pkg::WaveW-1:0]  wave_q;
	logic [ssd_pkg::FreqW-1:0]  freq_q;
	logic [ssd_pkg::AmpW-1:0]   amp_q;
	logic [ssd_pkg::DwellW-1:0] dwell_q;
	logic [ssd_pkg::PosW-1:0]   scan_q;
	logic [ssd_pkg::DwellW-1:0] count_q;
	logic [ssd_pkg::DwellW-1:0] count_inc;
	logic [ssd_pkg::DwellW-1:0] limit;
	logic [ssd_pkg::AmpW-1:0]   amp_sat;
	logic                       wr;

	assign wr        = psel && penable && pwrite;
	assign limit     = (dwell_q == '0) ? ssd_pkg::DwellW'(1) : dwell_q;
	assign count_inc = count_q + ssd_pkg::DwellW'(1);
	assign amp_sat   = (amp_q > ssd_pkg::AmpMax) ? ssd_pkg::AmpMax : amp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q  <= '0;
			freq_q  <= '0;
			amp_q   <= '0;
			dwell_q <= ssd_pkg::DwellReset;
		end else if (wr) begin
			case (paddr[3:2])
				ssd_pkg::RegWaveMode:  wave_q  <= pwdata[ssd_pkg::WaveW-1:0];
				ssd_pkg::RegFrequency: freq_q  <= pwdata[ssd_pkg::FreqW-1:0];
				ssd_pkg::RegAmplitude: amp_q   <= pwdata[ssd_pkg::AmpW-1:0];
				ssd_pkg::RegDwell:     dwell_q <= pwdata[ssd_pkg::DwellW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ssd_pkg::RegWaveMode:  prdata = {{(ssd_pkg::DataW-ssd_pkg::WaveW){1'b0}}, wave_q};
			ssd_pkg::RegFrequency: prdata = {{(ssd_pkg::DataW-ssd_pkg::FreqW){1'b0}}, freq_q};
			ssd_pkg::RegAmplitude: prdata = {{(ssd_pkg::DataW-ssd_pkg::AmpW){1'b0}}, amp_q};
			ssd_pkg::RegDwell:     prdata = {{(ssd_pkg::DataW-ssd_pkg::DwellW){1'b0}}, dwell_q};
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			count_q <= '0;
		end else if (accept && tick) begin
			if (count_inc >= limit) begin
				count_q <= '0;
				scan_q  <= scan_q + ssd_pkg::PosW'(1);
			end else begin
				count_q <= count_inc;
			end
		end
	end

	always_comb begin
		entry       = '0;
		entry.pos   = scan_q;
		entry.blank = (freq_q < ssd_pkg::FreqLow) || (freq_q >= ssd_pkg::FreqHigh);
		entry.wave  = wave_q;
		entry.bin_f = freq_q;
		entry.bin_a = {1'b0, amp_sat};
	end

endmodule

[rtl/seven_segment_scan_display.sv]
// Eight-digit multiplexed seven-segment scan driver.
// Configuration goes through the APB port: wave mode at 0x0, frequency in Hz
// at 0x4, amplitude in tenths at 0x8, dwell in ticks at 0xC; pready is
// always high and reads return the register value.
// Each transfer on the tick channel (tick_valid high, tick_stall low) yields
// exactly one transfer on the display channel carrying port_word,
// digit_position and blank, in order.
// Each result passes through eight binary-to-decimal cells (two frequency
// bits and one amplitude bit per cell), the first of which loads at the
// transfer edge, and then through the output register.
// Throughput: one tick per clock while tick_stall is low; the cell chain and
// output register form a nine-deep pipeline with a per-stage handshake.
// A tick bit of zero still gives a result but does not advance the scan.
// Reset restores the register defaults (dwell 50), returns the scan to digit 0
// and empties the pipeline.
// When the receiver holds disp_stall, results back up into the chain; once all
// nine stages are full tick_stall is raised until the receiver takes a result.
module seven_segment_scan_display (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ssd_pkg::AddrW-1:0]   paddr,
	input  logic [ssd_pkg::DataW-1:0]   pwdata,
	output logic [ssd_pkg::DataW-1:0]   prdata,
	output logic                        pready,
	input  logic                        tick_valid,
	output logic                        tick_stall,
	input  logic                        tick,
	output logic                        disp_valid,
	input  logic                        disp_stall,
	output logic [15:0]                 port_word,
	output logic [ssd_pkg::PosW-1:0]    digit_position,
	output logic                        blank
);

	ssd_pkg::item_t                 chain [ssd_pkg::NumCells+1];
	logic [ssd_pkg::NumCells:0]     valid_c;
	logic [ssd_pkg::NumCells:0]     ready_c;
	logic                           accept;
	logic                           out_ready;
	logic                           out_valid_q;
	logic [15:0]                    word_q;
	logic [ssd_pkg::PosW-1:0]       pos_q;
	logic                           blank_q;
	logic [7:0]                     seg;
	logic [7:0]                     sel;
	ssd_pkg::item_t                 fin;

	assign pready     = 1'b1;
	assign tick_stall = !ready_c[0];
	assign accept     = tick_valid && ready_c[0];
	assign valid_c[0] = tick_valid;

	ssd_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.accept  (accept),
		.tick    (tick),
		.entry   (chain[0])
	);

	for (genvar i = 0; i < ssd_pkg::NumCells; i++) begin : g_cell
		ssd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.item_in   (chain[i]),
			.valid_in  (valid_c[i]),
			.ready_up  (ready_c[i]),
			.ready_dn  (ready_c[i+1]),
			.item_out  (chain[i+1]),
			.valid_out (valid_c[i+1])
		);
	end

	assign out_ready                  = !out_valid_q || !disp_stall;
	assign ready_c[ssd_pkg::NumCells] = out_ready;
	assign fin                        = chain[ssd_pkg::NumCells];

	always_comb begin
		case (fin.pos)
			ssd_pkg::PosMode:     seg = ssd_pkg::glyph(fin.wave);
			ssd_pkg::PosDashA:    seg = ssd_pkg::SegDash;
			ssd_pkg::PosFreqTens: seg = ssd_pkg::glyph(fin.bcd_f[19:16]);
			ssd_pkg::PosFreqUnit: seg = ssd_pkg::glyph(fin.bcd_f[15:12]) | ssd_pkg::SegDot;
			ssd_pkg::PosFreqFrac: seg = ssd_pkg::glyph(fin.bcd_f[11:8]);
			ssd_pkg::PosDashB:    seg = ssd_pkg::SegDash;
			ssd_pkg::PosAmpUnit:  seg = ssd_pkg::glyph(fin.bcd_a[7:4]) | ssd_pkg::SegDot;
			ssd_pkg::PosAmpFrac:  seg = ssd_pkg::glyph(fin.bcd_a[3:0]);
			default:              seg = ssd_pkg::SegDash;
		endcase
		sel = 8'd1 << fin.pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_c[ssd_pkg::NumCells];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_c[ssd_pkg::NumCells]) begin
			word_q  <= fin.blank ? ssd_pkg::BlankWord : {sel, seg};
			pos_q   <= fin.pos;
			blank_q <= fin.blank;
		end
	end

	assign disp_valid     = out_valid_q;
	assign port_word      = word_q;
	assign digit_position = pos_q;
	assign blank          = blank_q;

endmodule

[rtl/ssd_checker.sv]
module ssd_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     tick_valid,
	input logic                     tick_stall,
	input logic                     disp_valid,
	input logic                     disp_stall,
	input logic [15:0]              port_word,
	input logic [ssd_pkg::PosW-1:0] digit_position,
	input logic                     blank
);

	// nothing leaves while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !disp_valid)
		else $error("display transfer offered during reset");

	// a blank result always shows the all-ones word
	a_blank_word: assert property (@(posedge clk) disable iff (!arst_n)
		(disp_valid && blank) |-> (port_word == ssd_pkg::BlankWord))
		else $error("blank result without all-ones port word");

	// the digit select of a non-blank result follows the reported position
	a_digit_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(disp_valid && !blank) |-> (port_word[15:8] == (8'd1 << digit_position)))
		else $error("digit select does not match digit position");

	// an offered result is not withdrawn while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(disp_valid && disp_stall) |=> disp_valid)
		else $error("display result dropped while stalled");

	// an empty output stage never backs up the tick side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && !disp_valid) |-> !tick_stall)
		else $error("unexpected tick stall");

endmodule

bind seven_segment_scan_display ssd_checker u_ssd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.tick_valid     (tick_valid),
	.tick_stall     (tick_stall),
	.disp_valid     (disp_valid),
	.disp_stall     (disp_stall),
	.port_word      (port_word),
	.digit_position (digit_position),
	.blank          (blank)
);

[tb/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ssd_pkg::*;

	localparam int Items       = 550;
	localparam int DrainCycles = 12;
	localparam int IdleLimit   = 1000;
	localparam int HoldCycles  = 60;

	localparam logic [9:0][7:0] Font = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
		8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

	typedef struct packed {
		logic [15:0]     word;
		logic [PosW-1:0] pos;
		logic            blank;
	} disp_t;

	typedef struct packed {
		logic        is_write;
		logic [1:0]  idx;
		logic [31:0] data;
		logic        t;
		logic        typed;
		disp_t       want;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [AddrW-1:0]  paddr;
	logic [DataW-1:0]  pwdata;
	logic [DataW-1:0]  prdata;
	logic              pready;
	logic              tick_valid;
	logic              tick_stall;
	logic              tick;
	logic              disp_valid;
	logic              disp_stall;
	logic [15:0]       port_word;
	logic [PosW-1:0]   digit_position;
	logic              blank;

	seven_segment_scan_display dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.tick_valid     (tick_valid),
		.tick_stall     (tick_stall),
		.tick           (tick),
		.disp_valid     (disp_valid),
		.disp_stall     (disp_stall),
		.port_word      (port_word),
		.digit_position (digit_position),
		.blank          (blank)
	);

	logic [WaveW-1:0]  cfg_wave  = '0;
	logic [FreqW-1:0]  cfg_freq  = '0;
	logic [AmpW-1:0]   cfg_amp   = '0;
	logic [DwellW-1:0] cfg_dwell = DwellReset;
	logic [PosW-1:0]   scan_pos  = '0;
	logic [DwellW-1:0] dwell_cnt = '0;

	disp_t  pending_digits[$];
	int     errors      = 0;
	int     idle_cycles = 0;
	logic   hold_req    = 1'b0;
	logic   row_typed   = 1'b0;
	disp_t  row_want    = '0;
	row_t   plan[$];

	function automatic disp_t next_display(input logic t);
		disp_t             r;
		logic [7:0]        seg;
		logic [AmpW-1:0]   a;
		int unsigned       f;
		logic [DwellW-1:0] lim;
		a = (cfg_amp > AmpMax) ? AmpMax : cfg_amp;
		f = cfg_freq;
		case (scan_pos)
			PosMode:              seg = (cfg_wave <= 4'd9) ? Font[cfg_wave] : SegDash;
			PosDashA, PosDashB:   seg = SegDash;
			PosFreqTens:          seg = Font[(f / 10000) % 10];
			PosFreqUnit:          seg = Font[(f % 10000) / 1000] | SegDot;
			PosFreqFrac:          seg = Font[(f / 100) % 10];
			PosAmpUnit:           seg = Font[a / 10] | SegDot;
			default:              seg = Font[a % 10];
		endcase
		r.pos   = scan_pos;
		r.blank = (cfg_freq < FreqLow) || (cfg_freq >= FreqHigh);
		r.word  = r.blank ? BlankWord : ((16'h0100 << scan_pos) | {8'h00, seg});
		if (t) begin
			lim = (cfg_dwell == '0) ? 16'd1 : cfg_dwell;
			dwell_cnt = dwell_cnt + 1'b1;
			if (dwell_cnt >= lim) begin
				dwell_cnt = '0;
				scan_pos  = scan_pos + 1'b1;
			end
		end
		return r;
	endfunction

	function automatic void apply_config(input logic [1:0] idx, input logic [31:0] data);
		case (idx)
			RegWaveMode:  cfg_wave  = data[WaveW-1:0];
			RegFrequency: cfg_freq  = data[FreqW-1:0];
			RegAmplitude: cfg_amp   = data[AmpW-1:0];
			RegDwell:     cfg_dwell = data[DwellW-1:0];
			default: ;
		endcase
	endfunction

	function automatic row_t write_row(input logic [1:0] idx, input logic [31:0] data);
		row_t r;
		r = '0;
		r.is_write = 1'b1;
		r.idx      = idx;
		r.data     = data;
		return r;
	endfunction

	function automatic row_t tick_row(input logic t);
		row_t r;
		r = '0;
		r.t = t;
		return r;
	endfunction

	function automatic row_t tick_row_typed(input logic t, input disp_t want);
		row_t r;
		r = tick_row(t);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_tick(input logic t, input logic typed, input disp_t want);
		tick_valid = 1'b1;
		tick       = t;
		row_typed  = typed;
		row_want   = want;
		do @(posedge clk); while (tick_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		tick_valid = 1'b0;
		while (pending_digits.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		apply_config(idx, data);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin : check
		disp_t e;
		if (arst_n) begin
			if (tick_valid && !tick_stall) begin
				e = next_display(tick);
				if (row_typed)
					e = row_want;
				pending_digits.push_back(e);
			end
			if (disp_valid && !disp_stall) begin
				if (pending_digits.size() == 0) begin
					report_mismatch("result with nothing pending", port_word, '0);
				end else begin
					e = pending_digits.pop_front();
					if (port_word !== e.word)
						report_mismatch("port_word", port_word, e.word);
					if (digit_position !== e.pos)
						report_mismatch("digit_position", 16'(digit_position), 16'(e.pos));
					if (blank !== e.blank)
						report_mismatch("blank", 16'(blank), 16'(e.blank));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (disp_valid && !disp_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver stall pattern, with a long hold when asked
	initial begin : receiver
		int mode;
		int span;
		disp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 100);
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				if (hold_req) begin
					disp_stall = 1'b1;
					repeat (HoldCycles) @(negedge clk);
					hold_req = 1'b0;
				end
				case (mode)
					0: disp_stall = 1'b0;
					1: disp_stall = ($urandom_range(0, 9) < 3);
					2: disp_stall = ($urandom_range(0, 9) < 7);
					default: disp_stall = i[1];
				endcase
			end
		end
	end

	initial begin : stimulus
		int          sent;
		int          phase;
		int          n;
		int          burst;
		int          gap;
		logic [31:0] data;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		tick_valid = 1'b0;
		tick       = 1'b0;
		arst_n     = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// frequency 0 after reset, so the display is blanked on digit 0
		plan.push_back(tick_row_typed(1'b1, '{BlankWord, PosMode, 1'b1}));
		plan.push_back(tick_row_typed(1'b0, '{BlankWord, PosMode, 1'b1}));
		plan.push_back(write_row(RegDwell, 32'd0));
		plan.push_back(write_row(RegFrequency, 32'd100));
		plan.push_back(write_row(RegWaveMode, 32'd9));
		plan.push_back(write_row(RegAmplitude, 32'd127));
		for (int i = 0; i < 8; i++)
			plan.push_back(tick_row(1'b1));
		plan.push_back(tick_row(1'b0));
		plan.push_back(write_row(RegFrequency, 32'd19999));
		plan.push_back(write_row(RegWaveMode, 32'd10));
		plan.push_back(write_row(RegAmplitude, 32'd0));
		plan.push_back(write_row(RegDwell, 32'd1));
		for (int i = 0; i < 8; i++)
			plan.push_back(tick_row(1'b1));
		plan.push_back(write_row(RegFrequency, 32'd20000));
		plan.push_back(tick_row(1'b1));
		plan.push_back(tick_row(1'b1));
		plan.push_back(write_row(RegFrequency, 32'd99));
		plan.push_back(tick_row(1'b1));
		plan.push_back(write_row(RegFrequency, 32'hFFFF_FFFF));
		plan.push_back(write_row(RegWaveMode, 32'hFFFF_FFFF));
		plan.push_back(write_row(RegAmplitude, 32'd99));
		plan.push_back(write_row(RegDwell, 32'd65535));
		plan.push_back(tick_row(1'b1));
		plan.push_back(tick_row(1'b1));

		foreach (plan[i]) begin
			if (plan[i].is_write)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_tick(plan[i].t, plan[i].typed, plan[i].want);
		end
		tick_valid = 1'b0;

		sent  = 0;
		phase = 0;
		while (sent < Items) begin
			data = $urandom;
			data[WaveW-1:0] = 4'($urandom_range(0, 15));
			write_reg(RegWaveMode, data);
			data = $urandom;
			case ($urandom_range(0, 9))
				0: data[FreqW-1:0] = 16'($urandom_range(0, 99));
				1: data[FreqW-1:0] = 16'($urandom_range(20000, 65535));
				2: data[FreqW-1:0] = ($urandom_range(0, 1) == 1) ? 16'd100 : 16'd19999;
				default: data[FreqW-1:0] = 16'($urandom_range(100, 19999));
			endcase
			write_reg(RegFrequency, data);
			data = $urandom;
			data[AmpW-1:0] = 7'($urandom_range(0, 127));
			write_reg(RegAmplitude, data);
			data = $urandom;
			case ($urandom_range(0, 9))
				0: data[DwellW-1:0] = 16'd0;
				1: data[DwellW-1:0] = 16'd65535;
				2: data[DwellW-1:0] = 16'($urandom_range(5, 40));
				default: data[DwellW-1:0] = 16'($urandom_range(1, 4));
			endcase
			write_reg(RegDwell, data);

			n = $urandom_range(25, 70);
			// long receiver hold while the sender keeps offering
			if (phase == 2)
				hold_req = 1'b1;
			while (n > 0) begin
				burst = $urandom_range(1, 16);
				for (int k = 0; k < burst && n > 0; k++) begin
					send_tick($urandom_range(0, 9) != 0, 1'b0, '0);
					n--;
					sent++;
				end
				gap = ($urandom_range(0, 2) == 0 || phase == 2) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					tick_valid = 1'b0;
					tick       = 1'($urandom);
					repeat (gap) @(negedge clk);
				end
			end
			tick_valid = 1'b0;
			phase++;
		end

		while (pending_digits.size() != 0) @(negedge clk);
		repeat (2 * DrainCycles) @(negedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/ssd_pkg.sv
rtl/ssd_cell.sv
rtl/ssd_scan.sv
rtl/seven_segment_scan_display.sv
rtl/ssd_checker.sv
tb/testbench.sv
